/* rtl/core/sse_pkg.sv */
package sse_pkg;

    localparam int unsigned SAMPLE_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAND,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_MEAN,
        S_MEAN_W,
        S_MUL1,
        S_MUL2,
        S_VAR,
        S_VAR_W,
        S_SQRT,
        S_OUT
    } t_back_state;

endpackage

/* rtl/core/sample_statistics_engine.sv */
// Descriptive statistics over one set of unsigned 32-bit samples.
// Input: a sample with its last flag is taken at a clock edge where start is
// high and busy is low. Samples load one per cycle while busy is low. Up to MAX_SAMPLES are
// kept; later ones are dropped and reported through o_overflowed.
// After the sample marked last, busy stays high until the result is shown.
// The result (min, max, mean, median, std dev, count, overflow) is on the
// outputs for exactly one cycle with o_valid high; the receiver cannot stall.
// Steps after the last sample, for n kept samples:
//   median search: c candidates, c <= n (rank counting over a second
//   read port of the sample store);
//   mean and variance divisions: two runs of a radix-2 divider
//   (DW = 64 + 2*clog2(MAX_SAMPLES+1) + 2*FRACTION_BITS, 94 by default);
//   shift-add products over the bits of n and of the sum;
//   square root: one result bit per cycle.
// Reset clears the running statistics and the job queue; the sample store
// needs no clearing, since only entries written in the current set are read.
module sample_statistics_engine #(
    parameter int unsigned MAX_SAMPLES   = 64,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [31:0]                            i_sample,
    input  logic                                   i_last,
    output logic                                   o_valid,
    output logic [31:0]                            o_minimum,
    output logic [31:0]                            o_maximum,
    output logic [31+FRACTION_BITS:0]              o_mean_q8,
    output logic [31:0]                            o_median,
    output logic [31+FRACTION_BITS:0]              o_std_dev_q8,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]       o_sample_count,
    output logic                                   o_overflowed
);

    localparam int unsigned XW = sse_pkg::SAMPLE_W;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned SW = XW + CW;
    localparam int unsigned JW = CW + 2 * XW + SW + 1;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [XW-1:0] w_wdata;
    logic          w_push;
    logic [JW-1:0] w_job_in;
    logic          w_pop;
    logic          w_job_valid;
    logic [JW-1:0] w_job_out;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    logic [XW-1:0] w_rdata_a;
    logic [XW-1:0] w_rdata_b;

    sse_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .AW          (AW),
        .SW          (SW),
        .JW          (JW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_done   (o_valid),
        .o_busy   (busy),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    // Two copies of the store give the rank search two read ports.
    sse_ram #(
        .WIDTH (XW),
        .DEPTH (MAX_SAMPLES)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    sse_ram #(
        .WIDTH (XW),
        .DEPTH (MAX_SAMPLES)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    sse_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_data  (w_job_out)
    );

    sse_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .CW            (CW),
        .AW            (AW),
        .SW            (SW),
        .JW            (JW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_raddr_a      (w_raddr_a),
        .o_raddr_b      (w_raddr_b),
        .i_rdata_a      (w_rdata_a),
        .i_rdata_b      (w_rdata_b),
        .o_valid        (o_valid),
        .o_minimum      (o_minimum),
        .o_maximum      (o_maximum),
        .o_mean_q8      (o_mean_q8),
        .o_median       (o_median),
        .o_std_dev_q8   (o_std_dev_q8),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while the block accepts samples");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !busy)
        else $error("sample store written during processing");

endmodule

/* rtl/core/sse_ram.sv */
module sse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sse_queue.sv */
module sse_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             n_wp;
    logic             n_rp;
    logic [1:0]       n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push || i_pop)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("job queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("job queue count out of range");

endmodule

/* rtl/core/sse_div.sv */
module sse_div #(
    parameter int unsigned NW  = 64,
    parameter int unsigned DVW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_num,
    input  logic [DVW-1:0] i_den,
    output logic           o_done,
    output logic [NW-1:0]  o_quo
);

    localparam int unsigned CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_q;
    logic [DVW-1:0]  r_rem;
    logic [DVW-1:0]  r_den;
    logic [DVW:0]    w_trial;
    logic            w_ge;

    // One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
    assign w_trial = {r_rem, r_q[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? DVW'(w_trial - {1'b0, r_den}) : DVW'(w_trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a running division");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_den != '0))
        else $error("divider started with zero divisor");

endmodule

/* rtl/core/sse_front.sv */
module sse_front #(
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned CW          = 7,
    parameter int unsigned AW          = 6,
    parameter int unsigned SW          = 39,
    parameter int unsigned JW          = 111
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sse_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_last,
    input  logic                         i_done,
    output logic                         o_busy,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [sse_pkg::SAMPLE_W-1:0] o_wdata,
    output logic                         o_push,
    output logic [JW-1:0]                o_job
);

    localparam int unsigned XW = sse_pkg::SAMPLE_W;

    logic [CW-1:0] r_kept;
    logic [XW-1:0] r_min;
    logic [XW-1:0] r_max;
    logic [SW-1:0] r_sum;
    logic          r_drop;
    logic          r_busy;
    logic [CW-1:0] n_kept;
    logic [XW-1:0] n_min;
    logic [XW-1:0] n_max;
    logic [SW-1:0] n_sum;
    logic          n_drop;
    logic          w_accept;
    logic          w_room;

    assign w_accept = i_start && !r_busy;
    assign w_room   = (r_kept < CW'(MAX_SAMPLES));

    always_comb begin
        n_kept = r_kept;
        n_min  = r_min;
        n_max  = r_max;
        n_sum  = r_sum;
        n_drop = r_drop;
        if (w_room) begin
            n_kept = r_kept + 1'b1;
            n_min  = (i_sample < r_min) ? i_sample : r_min;
            n_max  = (i_sample > r_max) ? i_sample : r_max;
            n_sum  = r_sum + SW'(i_sample);
        end else begin
            n_drop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
            r_min  <= '1;
            r_max  <= '0;
            r_sum  <= '0;
            r_drop <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (w_accept && i_last) begin
                // The set is handed to the back end; start a fresh one.
                r_kept <= '0;
                r_min  <= '1;
                r_max  <= '0;
                r_sum  <= '0;
                r_drop <= 1'b0;
                r_busy <= 1'b1;
            end else if (w_accept) begin
                r_kept <= n_kept;
                r_min  <= n_min;
                r_max  <= n_max;
                r_sum  <= n_sum;
                r_drop <= n_drop;
            end else if (i_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_we    = w_accept && w_room;
    assign o_waddr = r_kept[AW-1:0];
    assign o_wdata = i_sample;
    assign o_push  = w_accept && i_last;
    assign o_job   = {n_kept, n_min, n_max, n_sum, n_drop};

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (n_kept != '0))
        else $error("set handed over with no kept samples");
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= CW'(MAX_SAMPLES))
        else $error("kept count beyond store size");
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_busy && (r_kept == '0))
        else $error("front not waiting after last sample");

endmodule

/* rtl/core/sse_back.sv */
module sse_back #(
    parameter int unsigned FRACTION_BITS = 8,
    parameter int unsigned CW            = 7,
    parameter int unsigned AW            = 6,
    parameter int unsigned SW            = 39,
    parameter int unsigned JW            = 111
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  logic [JW-1:0]                i_job,
    output logic                         o_pop,
    output logic [AW-1:0]                o_raddr_a,
    output logic [AW-1:0]                o_raddr_b,
    input  logic [sse_pkg::SAMPLE_W-1:0] i_rdata_a,
    input  logic [sse_pkg::SAMPLE_W-1:0] i_rdata_b,
    output logic                         o_valid,
    output logic [sse_pkg::SAMPLE_W-1:0] o_minimum,
    output logic [sse_pkg::SAMPLE_W-1:0] o_maximum,
    output logic [31+FRACTION_BITS:0]    o_mean_q8,
    output logic [sse_pkg::SAMPLE_W-1:0] o_median,
    output logic [31+FRACTION_BITS:0]    o_std_dev_q8,
    output logic [CW-1:0]                o_sample_count,
    output logic                         o_overflowed
);

    localparam int unsigned XW   = sse_pkg::SAMPLE_W;
    localparam int unsigned F    = FRACTION_BITS;
    localparam int unsigned QW   = 2 * XW + CW;
    localparam int unsigned PW   = 2 * XW + 2 * CW;
    localparam int unsigned DW   = PW + 2 * F;
    localparam int unsigned VW   = 2 * XW + 2 * F;
    localparam int unsigned OW   = XW + F;
    localparam int unsigned SQCW = $clog2(OW + 1);

    sse_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]     r_n;
    logic [XW-1:0]     r_min;
    logic [XW-1:0]     r_max;
    logic [SW-1:0]     r_sum;
    logic              r_drop;
    logic [AW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_j, n_j;
    logic              r_dv;
    logic [CW-1:0]     r_lt, n_lt;
    logic [CW-1:0]     r_le, n_le;
    logic [2*XW-1:0]   r_sq;
    logic              r_sqv;
    logic [QW-1:0]     r_sumsq, n_sumsq;
    logic              r_fhi, n_fhi;
    logic              r_flo, n_flo;
    logic [XW-1:0]     r_mhi, n_mhi;
    logic [XW-1:0]     r_mlo, n_mlo;
    logic [OW-1:0]     r_mean, n_mean;
    logic [PW-1:0]     r_ma, n_ma;
    logic [SW-1:0]     r_mb, n_mb;
    logic [PW-1:0]     r_acc, n_acc;
    logic [PW-1:0]     r_p1, n_p1;
    logic [VW-1:0]     r_v, n_v;
    logic [OW+1:0]     r_rem, n_rem;
    logic [OW-1:0]     r_root, n_root;
    logic [SQCW-1:0]   r_cnt, n_cnt;

    logic              w_div_start;
    logic [DW-1:0]     w_div_num;
    logic [2*CW-1:0]   w_div_den;
    logic              w_div_done;
    logic [DW-1:0]     w_div_quo;
    logic [AW-1:0]     w_last_idx;
    logic [CW-1:0]     w_k1;
    logic [CW-1:0]     w_k0;
    logic              w_hit_hi;
    logic              w_hit_lo;
    logic [OW+1:0]     w_sq_t;
    logic [OW+1:0]     w_sq_trial;
    logic [XW:0]       w_mid_sum;

    assign w_last_idx = AW'(r_n - 1'b1);
    assign w_k1       = r_n >> 1;
    assign w_k0       = r_n[0] ? w_k1 : w_k1 - 1'b1;
    // A candidate holds rank k when fewer than k+1 values are below it
    // and more than k values are at or below it.
    assign w_hit_hi   = (r_lt <= w_k1) && (w_k1 < r_le);
    assign w_hit_lo   = (r_lt <= w_k0) && (w_k0 < r_le);
    assign w_sq_t     = {r_rem[OW-1:0], r_v[VW-1:VW-2]};
    assign w_sq_trial = {r_root, 2'b01};

    sse_div #(
        .NW  (DW),
        .DVW (2 * CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_lt        = r_lt;
        n_le        = r_le;
        n_sumsq     = r_sumsq;
        n_fhi       = r_fhi;
        n_flo       = r_flo;
        n_mhi       = r_mhi;
        n_mlo       = r_mlo;
        n_mean      = r_mean;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_acc       = r_acc;
        n_p1        = r_p1;
        n_v         = r_v;
        n_rem       = r_rem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = DW'(r_sum) << F;
        w_div_den   = (2 * CW)'(r_n);

        if (r_dv) begin
            n_lt = r_lt + CW'(i_rdata_b < i_rdata_a);
            n_le = r_le + CW'(i_rdata_b <= i_rdata_a);
        end
        if (r_sqv) begin
            n_sumsq = r_sumsq + QW'(r_sq);
        end

        unique case (r_state)
            sse_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_i     = '0;
                    n_sumsq = '0;
                    n_fhi   = 1'b0;
                    n_flo   = 1'b0;
                    n_state = sse_pkg::S_CAND;
                end
            end
            sse_pkg::S_CAND: begin
                n_j     = '0;
                n_lt    = '0;
                n_le    = '0;
                n_state = sse_pkg::S_SCAN;
            end
            sse_pkg::S_SCAN: begin
                if (r_j == w_last_idx) begin
                    n_state = sse_pkg::S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            sse_pkg::S_DRAIN: begin
                n_state = sse_pkg::S_EVAL;
            end
            sse_pkg::S_EVAL: begin
                if (w_hit_hi && !r_fhi) begin
                    n_fhi = 1'b1;
                    n_mhi = i_rdata_a;
                end
                if (w_hit_lo && !r_flo) begin
                    n_flo = 1'b1;
                    n_mlo = i_rdata_a;
                end
                if (((r_fhi || w_hit_hi) && (r_flo || w_hit_lo)) || (r_i == w_last_idx)) begin
                    n_state = sse_pkg::S_MEAN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = sse_pkg::S_CAND;
                end
            end
            sse_pkg::S_MEAN: begin
                w_div_start = 1'b1;
                n_state     = sse_pkg::S_MEAN_W;
            end
            sse_pkg::S_MEAN_W: begin
                if (w_div_done) begin
                    n_mean  = w_div_quo[OW-1:0];
                    n_acc   = '0;
                    n_ma    = PW'(r_sumsq);
                    n_mb    = SW'(r_n);
                    n_state = sse_pkg::S_MUL1;
                end
            end
            sse_pkg::S_MUL1: begin
                if (r_mb == '0) begin
                    n_p1    = r_acc;
                    n_acc   = '0;
                    n_ma    = PW'(r_sum);
                    n_mb    = r_sum;
                    n_state = sse_pkg::S_MUL2;
                end else begin
                    if (r_mb[0]) begin
                        n_acc = r_acc + r_ma;
                    end
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end
            sse_pkg::S_MUL2: begin
                if (r_mb == '0) begin
                    n_state = sse_pkg::S_VAR;
                end else begin
                    if (r_mb[0]) begin
                        n_acc = r_acc + r_ma;
                    end
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end
            sse_pkg::S_VAR: begin
                // n*sum(x^2) - sum^2, scaled, over n^2 gives the scaled variance.
                w_div_start = 1'b1;
                w_div_num   = DW'(r_p1 - r_acc) << (2 * F);
                w_div_den   = (2 * CW)'(r_n) * (2 * CW)'(r_n);
                n_state     = sse_pkg::S_VAR_W;
            end
            sse_pkg::S_VAR_W: begin
                if (w_div_done) begin
                    n_v     = w_div_quo[VW-1:0];
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = sse_pkg::S_SQRT;
                end
            end
            sse_pkg::S_SQRT: begin
                if (w_sq_t >= w_sq_trial) begin
                    n_rem  = w_sq_t - w_sq_trial;
                    n_root = {r_root[OW-2:0], 1'b1};
                end else begin
                    n_rem  = w_sq_t;
                    n_root = {r_root[OW-2:0], 1'b0};
                end
                n_v   = r_v << 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQCW'(OW - 1)) begin
                    n_state = sse_pkg::S_OUT;
                end
            end
            sse_pkg::S_OUT: begin
                n_state = sse_pkg::S_IDLE;
            end
            default: begin
                n_state = sse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::S_IDLE;
            r_dv    <= 1'b0;
            r_sqv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == sse_pkg::S_SCAN);
            r_sqv   <= r_dv && (r_i == '0);
        end
        if (o_pop) begin
            {r_n, r_min, r_max, r_sum, r_drop} <= i_job;
        end
        r_sq    <= (2 * XW)'(i_rdata_b * i_rdata_b);
        r_i     <= n_i;
        r_j     <= n_j;
        r_lt    <= n_lt;
        r_le    <= n_le;
        r_sumsq <= n_sumsq;
        r_fhi   <= n_fhi;
        r_flo   <= n_flo;
        r_mhi   <= n_mhi;
        r_mlo   <= n_mlo;
        r_mean  <= n_mean;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_acc   <= n_acc;
        r_p1    <= n_p1;
        r_v     <= n_v;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_cnt   <= n_cnt;
    end

    assign w_mid_sum      = {1'b0, r_mlo} + {1'b0, r_mhi};
    assign o_raddr_a      = r_i;
    assign o_raddr_b      = r_j;
    assign o_valid        = (r_state == sse_pkg::S_OUT);
    assign o_minimum      = r_min;
    assign o_maximum      = r_max;
    assign o_mean_q8      = r_mean;
    assign o_median       = w_mid_sum[XW:1];
    assign o_std_dev_q8   = r_root;
    assign o_sample_count = r_n;
    assign o_overflowed   = r_drop;

    a_median_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::S_MEAN) |-> r_fhi && r_flo)
        else $error("median ranks not found before statistics phase");
    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::S_EVAL) |-> (r_lt <= r_le) && (r_le <= r_n))
        else $error("rank counts inconsistent");
    a_var_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::S_VAR) |-> (r_p1 >= r_acc))
        else $error("negative variance numerator");
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_min <= r_max) && (r_n != '0))
        else $error("result with inconsistent extremes or no samples");

endmodule
